[rtl/core/lsh_pkg.sv]
`default_nettype none

package lsh_pkg;

	localparam int SMP_W      = 8;
	localparam int ROW_W      = 12;
	localparam int IDX_W      = 13;
	localparam int FW_W       = 12;
	localparam int FH_W       = 13;
	localparam int CC_W       = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int OUT_DATA_W = 40;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	localparam logic [FW_W-1:0] FW_RESET = 12'd640;
	localparam logic [FH_W-1:0] FH_RESET = 13'd480;
	localparam logic [CC_W-1:0] CC_RESET = 3'd1;

	localparam logic [FH_W-1:0] H_MIN = 13'd3;
	localparam logic [FH_W-1:0] H_MAX = 13'd4096;
	localparam int              W_MIN = 3;

	// position of one accepted item after counter normalization
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [IDX_W-1:0] idx;
		logic             interior;
		logic             last_row;
	} pos_t;

	// 3x3 cross neighborhood, all row r-1 except up (row r-2)
	typedef struct packed {
		logic [SMP_W-1:0] mid_c;
		logic [SMP_W-1:0] mid_r;
		logic [SMP_W-1:0] up_c;
		logic [SMP_W-1:0] up_l;
	} pix_t;

endpackage

`default_nettype wire

[rtl/core/lsh_ctrl.sv]
`default_nettype none

module lsh_ctrl #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_CHANNELS = 4,
	parameter int IXW          = 13
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [lsh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsh_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                         accept,
	output lsh_pkg::pos_t                     pos,
	output logic                              has_res,
	output logic [IXW-1:0]                    rd_addr,
	output logic [lsh_pkg::CC_W-1:0]          step
);
	import lsh_pkg::*;

	localparam int BW = IXW + 1;
	localparam logic [13:0] MAXW = 14'(MAX_WIDTH);
	localparam logic [CC_W-1:0] MAXC = CC_W'(MAX_CHANNELS);

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [CC_W-1:0]  cc_q;
	logic [ROW_W-1:0] row_q;
	logic [IXW-1:0]   idx_q;

	logic [13:0]      w_cl;
	logic [FH_W-1:0]  h_cl;
	logic [CC_W-1:0]  c_cl;
	logic [BW-1:0]    bytes;
	logic             wrap_i;
	logic [FH_W-1:0]  r_a;
	logic [FH_W-1:0]  r_n;
	logic [FH_W-1:0]  r_inc;
	logic [IXW-1:0]   i_n;
	logic [BW-1:0]    i_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_RESET;
			fh_q <= FH_RESET;
			cc_q <= CC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:   fw_q <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT:  fh_q <= cfg_data[FH_W-1:0];
				REG_CHANNEL_COUNT: cc_q <= cfg_data[CC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if ({2'b0, fw_q} < 14'(W_MIN)) begin
			w_cl = 14'(W_MIN);
		end else if ({2'b0, fw_q} > MAXW) begin
			w_cl = MAXW;
		end else begin
			w_cl = {2'b0, fw_q};
		end
		if (fh_q < H_MIN) begin
			h_cl = H_MIN;
		end else if (fh_q > H_MAX) begin
			h_cl = H_MAX;
		end else begin
			h_cl = fh_q;
		end
		if (cc_q == '0) begin
			c_cl = CC_W'(1);
		end else if (cc_q > MAXC) begin
			c_cl = MAXC;
		end else begin
			c_cl = cc_q;
		end
		bytes = BW'(w_cl * c_cl);

		// restart counters that a register change left out of range
		wrap_i = {1'b0, idx_q} >= bytes;
		r_a    = wrap_i ? ({1'b0, row_q} + FH_W'(1)) : {1'b0, row_q};
		r_n    = (r_a >= h_cl) ? '0 : r_a;
		i_n    = wrap_i ? '0 : idx_q;
		i_inc  = {1'b0, i_n} + BW'(1);
		r_inc  = r_n + FH_W'(1);

		pos.row      = r_n[ROW_W-1:0];
		pos.idx      = IDX_W'(i_n);
		pos.interior = (r_n >= FH_W'(2)) && ({1'b0, i_n} >= BW'(c_cl))
		               && ({1'b0, i_n} < (bytes - BW'(c_cl)));
		pos.last_row = (r_n == (h_cl - FH_W'(1)));
		has_res      = (r_n != '0);
		rd_addr      = i_n;
		step         = c_cl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			idx_q <= '0;
		end else if (accept) begin
			if (i_inc >= bytes) begin
				idx_q <= '0;
				row_q <= (r_inc >= h_cl) ? '0 : r_inc[ROW_W-1:0];
			end else begin
				idx_q <= i_inc[IXW-1:0];
				row_q <= r_n[ROW_W-1:0];
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_we |=> {1'b0, idx_q} < bytes)
		else $error("index counter beyond row length after an item");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_we |=> {1'b0, row_q} < h_cl)
		else $error("row counter beyond frame height after an item");

endmodule

`default_nettype wire

[rtl/core/lsh_line_buf.sv]
`default_nettype none

module lsh_line_buf #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      rd_en,
	input  wire logic [AW-1:0]             rd_addr,
	input  wire logic [lsh_pkg::CC_W-1:0]  step,
	input  wire logic [lsh_pkg::SMP_W-1:0] sample,
	output lsh_pkg::pix_t                  pix
);
	import lsh_pkg::*;

	logic [SMP_W-1:0] mid_mem [DEPTH];
	logic [SMP_W-1:0] up_mem  [DEPTH];

	logic [AW-1:0]    a_r;
	logic [AW-1:0]    a_l;
	logic             wr_pend_q;
	logic [AW-1:0]    wr_addr_q;
	logic [SMP_W-1:0] wr_mid_q;
	logic [SMP_W-1:0] rd_mc_q;
	logic [SMP_W-1:0] rd_mr_q;
	logic [SMP_W-1:0] rd_uc_q;
	logic [SMP_W-1:0] rd_ul_q;
	logic             hit_mc_q;
	logic             hit_mr_q;
	logic             hit_uc_q;
	logic             hit_ul_q;
	logic [SMP_W-1:0] fwd_mid_q;
	logic [SMP_W-1:0] fwd_up_q;
	logic [SMP_W-1:0] mid_c_res;

	assign a_r = rd_addr + AW'(step);
	assign a_l = rd_addr - AW'(step);

	// the previous item writes on the edge this item reads: forward it
	assign mid_c_res = hit_mc_q ? fwd_mid_q : rd_mc_q;
	assign pix.mid_c = mid_c_res;
	assign pix.mid_r = hit_mr_q ? fwd_mid_q : rd_mr_q;
	assign pix.up_c  = hit_uc_q ? fwd_up_q  : rd_uc_q;
	assign pix.up_l  = hit_ul_q ? fwd_up_q  : rd_ul_q;

	always_ff @(posedge clk) begin
		if (wr_pend_q) begin
			mid_mem[wr_addr_q] <= wr_mid_q;
			up_mem[wr_addr_q]  <= mid_c_res;
		end
		if (rd_en) begin
			rd_mc_q <= mid_mem[rd_addr];
			rd_mr_q <= mid_mem[a_r];
			rd_uc_q <= up_mem[rd_addr];
			rd_ul_q <= up_mem[a_l];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			wr_addr_q <= rd_addr;
			wr_mid_q  <= sample;
			hit_mc_q  <= wr_pend_q && (wr_addr_q == rd_addr);
			hit_mr_q  <= wr_pend_q && (wr_addr_q == a_r);
			hit_uc_q  <= wr_pend_q && (wr_addr_q == rd_addr);
			hit_ul_q  <= wr_pend_q && (wr_addr_q == a_l);
			fwd_mid_q <= wr_mid_q;
			fwd_up_q  <= mid_c_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_q <= 1'b0;
		end else begin
			wr_pend_q <= rd_en;
		end
	end

endmodule

`default_nettype wire

[rtl/core/lsh_kernel.sv]
`default_nettype none

module lsh_kernel (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire lsh_pkg::pos_t             pos,
	input  wire logic [lsh_pkg::SMP_W-1:0] sample,
	input  wire lsh_pkg::pix_t             pix,
	output logic                           take,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [lsh_pkg::SMP_W-1:0]      out_value,
	output logic [lsh_pkg::ROW_W-1:0]      out_row,
	output logic [lsh_pkg::IDX_W-1:0]      out_index,
	output logic                           out_last
);
	import lsh_pkg::*;

	logic             vld_s1;
	logic             phase_s1;
	pos_t             pos_s1;
	logic [SMP_W-1:0] smp_s1;

	logic             vld_s2;
	logic [SMP_W-1:0] val_s2;
	logic [ROW_W-1:0] row_s2;
	logic [IDX_W-1:0] idx_s2;
	logic             last_s2;

	logic             s2_free;
	logic             emit;
	logic             emit_last;
	logic [11:0]      acc;
	logic [SMP_W-1:0] sharp;

	assign s2_free   = !vld_s2 || out_ready;
	assign emit      = vld_s1 && s2_free;
	assign emit_last = phase_s1 || !pos_s1.last_row;
	assign take      = !vld_s1 || (s2_free && emit_last);

	always_comb begin
		acc = {2'b0, pix.mid_c, 2'b0} + {4'b0, pix.mid_c}
		      - {4'b0, pix.up_l} - {4'b0, pix.mid_r}
		      - {4'b0, pix.up_c} - {4'b0, smp_s1};
		if (acc[11]) begin
			sharp = '0;
		end else if (acc > 12'd255) begin
			sharp = '1;
		end else begin
			sharp = acc[SMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (load) begin
			vld_s1   <= 1'b1;
			phase_s1 <= 1'b0;
		end else if (emit && emit_last) begin
			vld_s1   <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (emit) begin
			phase_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pos_s1 <= pos;
			smp_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (emit) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	// last row: first the row above, then a zero for the item's own position
	always_ff @(posedge clk) begin
		if (emit) begin
			idx_s2 <= pos_s1.idx;
			if (phase_s1) begin
				val_s2  <= '0;
				row_s2  <= pos_s1.row;
				last_s2 <= 1'b1;
			end else begin
				val_s2  <= pos_s1.interior ? sharp : '0;
				row_s2  <= pos_s1.row - ROW_W'(1);
				last_s2 <= !pos_s1.last_row;
			end
		end
	end

	assign out_valid = vld_s2;
	assign out_value = val_s2;
	assign out_row   = row_s2;
	assign out_index = idx_s2;
	assign out_last  = last_s2;

	a_phase_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && phase_s1 |-> pos_s1.last_row)
		else $error("second result pending for an item outside the last row");

	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_s1) |-> vld_s2 && !last_s2)
		else $error("first of two results marked as final");

	a_take_idle_s1: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> vld_s1 && !phase_s1)
		else $error("loaded item not held in stage one");

endmodule

`default_nettype wire

[rtl/core/laplacian_sharpen_3x3_unit.sv]
`default_nettype none

// Channel   Dir  Payload (low bit first)
// s_axis    in   tdata: sample[7:0]
// m_axis    out  tdata: value[7:0], out_row[19:8], out_index[32:20], zero pad; tlast: last_of_run
// cfg       in   write only: 0 frame_width, 1 frame_height, 2 channel_count
//
// One item per cycle outside the last row while the output is not stalled; items are
// held in stage one, results in stage two. Last-row items yield two results in turn.
// Line stores are dual-read memories; a write lands in the cycle after its item,
// with forwarding into the next item's reads. No clearing pass after reset.
// A stalled output holds one more item in stage one, then drops s_axis_tready.

module laplacian_sharpen_3x3_unit #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lsh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsh_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [lsh_pkg::SMP_W-1:0]      s_axis_tdata,  // sample
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [lsh_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // value, out_row, out_index
	output logic                                m_axis_tlast
);
	import lsh_pkg::*;

	localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int IXW        = $clog2(LINE_DEPTH);

	pos_t             pos;
	pix_t             pix;
	logic             has_res;
	logic [IXW-1:0]   rd_addr;
	logic [CC_W-1:0]  step;
	logic             take;
	logic             accept;
	logic [SMP_W-1:0] value;
	logic [ROW_W-1:0] out_row;
	logic [IDX_W-1:0] out_index;

	assign s_axis_tready = take;
	assign accept        = s_axis_tvalid && take;

	lsh_ctrl #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS),
		.IXW          (IXW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.pos       (pos),
		.has_res   (has_res),
		.rd_addr   (rd_addr),
		.step      (step)
	);

	lsh_line_buf #(
		.DEPTH (LINE_DEPTH),
		.AW    (IXW)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.step    (step),
		.sample  (s_axis_tdata),
		.pix     (pix)
	);

	lsh_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && has_res),
		.pos       (pos),
		.sample    (s_axis_tdata),
		.pix       (pix),
		.take      (take),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (value),
		.out_row   (out_row),
		.out_index (out_index),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {
		(OUT_DATA_W - SMP_W - ROW_W - IDX_W)'(0), out_index, out_row, value
	};

endmodule

`default_nettype wire

[tb/laplacian_sharpen_3x3_unit_test.sv]
module laplacian_sharpen_3x3_unit_test;

	import lsh_pkg::*;

	localparam int MAX_W            = 2048;
	localparam int MAX_CH           = 4;
	localparam int STORE_DEPTH      = 8192;
	localparam int QUIET_CYCLES     = 8;
	localparam int RANDOM_PER_PHASE = 320;
	localparam int MAX_REPORTS      = 10;
	// widest row the random part configures, in pixels
	localparam int FILL_WIDTH       = 16;
	localparam int TALL_ROWS        = 8;

	// register index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int SEND_IDLE  [4] = '{0, 50, 0, 15};
	localparam int RECV_STALL [4] = '{0, 0, 50, 15};

	typedef struct packed {
		logic [SMP_W-1:0] value;
		logic [ROW_W-1:0] row;
		logic [IDX_W-1:0] index;
		logic             last;
	} sharp_result_t;

	typedef struct packed {
		logic [FH_W-1:0]  height;   // written before this item unless zero
		logic [SMP_W-1:0] sample;
		logic [1:0]       n_typed;  // zero: take the predictor's results
		sharp_result_t    first;
		sharp_result_t    second;
	} dir_row_t;

	// A 3x3 frame with a bright center that saturates high, then three rows of a
	// frame of height 5 with a dark center that saturates low.
	localparam dir_row_t DIR_TABLE [18] = '{
		'{13'd3, 8'd0,   2'd0, '0, '0},
		'{13'd0, 8'd0,   2'd0, '0, '0},
		'{13'd0, 8'd0,   2'd0, '0, '0},
		'{13'd0, 8'd0,   2'd1, '{8'd0, 12'd0, 13'd0, 1'b1}, '0},
		'{13'd0, 8'd255, 2'd1, '{8'd0, 12'd0, 13'd1, 1'b1}, '0},
		'{13'd0, 8'd0,   2'd1, '{8'd0, 12'd0, 13'd2, 1'b1}, '0},
		'{13'd0, 8'd0,   2'd2, '{8'd0, 12'd1, 13'd0, 1'b0}, '{8'd0, 12'd2, 13'd0, 1'b1}},
		'{13'd0, 8'd0,   2'd2, '{8'd255, 12'd1, 13'd1, 1'b0}, '{8'd0, 12'd2, 13'd1, 1'b1}},
		'{13'd0, 8'd0,   2'd2, '{8'd0, 12'd1, 13'd2, 1'b0}, '{8'd0, 12'd2, 13'd2, 1'b1}},
		'{13'd5, 8'd255, 2'd0, '0, '0},
		'{13'd0, 8'd255, 2'd0, '0, '0},
		'{13'd0, 8'd255, 2'd0, '0, '0},
		'{13'd0, 8'd255, 2'd1, '{8'd0, 12'd0, 13'd0, 1'b1}, '0},
		'{13'd0, 8'd0,   2'd1, '{8'd0, 12'd0, 13'd1, 1'b1}, '0},
		'{13'd0, 8'd255, 2'd1, '{8'd0, 12'd0, 13'd2, 1'b1}, '0},
		'{13'd0, 8'd255, 2'd0, '0, '0},
		'{13'd0, 8'd255, 2'd1, '{8'd0, 12'd1, 13'd1, 1'b1}, '0},
		'{13'd0, 8'd255, 2'd0, '0, '0}
	};

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [SMP_W-1:0]      s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	laplacian_sharpen_3x3_unit #(
		.MAX_WIDTH   (MAX_W),
		.MAX_CHANNELS(MAX_CH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always #1 clk = ~clk;

	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// predictor state
	logic [SMP_W-1:0] upper_store  [STORE_DEPTH];
	logic [SMP_W-1:0] middle_store [STORE_DEPTH];
	int unsigned      row_pos;
	int unsigned      byte_pos;
	logic [FW_W-1:0]  width_reg;
	logic [FH_W-1:0]  height_reg;
	logic [CC_W-1:0]  chan_reg;

	sharp_result_t sharp_expected [$];
	sharp_result_t got_result;
	sharp_result_t want_result;
	int            fail_count = 0;
	int            idle_pct   = 0;
	int            stall_pct  = 0;

	function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int unsigned cur_chans();
		return clamp_u(chan_reg, 1, MAX_CH);
	endfunction

	function automatic int unsigned cur_bytes();
		return clamp_u(width_reg, W_MIN, MAX_W) * cur_chans();
	endfunction

	function automatic int unsigned cur_height();
		return clamp_u(height_reg, H_MIN, H_MAX);
	endfunction

	task automatic predict_sharpen(input logic [SMP_W-1:0] smp, output int n,
			output sharp_result_t r0, output sharp_result_t r1);
		int unsigned c;
		int unsigned bytes;
		int unsigned h;
		int unsigned r;
		int unsigned i;
		int          acc;
		c     = cur_chans();
		bytes = cur_bytes();
		h     = cur_height();
		n     = 0;
		r0    = '0;
		r1    = '0;
		// counters left out of range by a register change restart here
		if (byte_pos >= bytes) begin
			byte_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		r = row_pos;
		i = byte_pos;
		if (r >= 1) begin
			acc = 0;
			if (r >= 2 && i >= c && i < bytes - c) begin
				acc = 5 * int'(middle_store[i]) - int'(upper_store[i - c])
					- int'(middle_store[i + c]) - int'(upper_store[i]) - int'(smp);
				if (acc < 0)
					acc = 0;
				if (acc > 255)
					acc = 255;
			end
			r0.value = acc[SMP_W-1:0];
			r0.row   = r - 1;
			r0.index = i;
			r0.last  = (r != h - 1);
			n        = 1;
			if (r == h - 1) begin
				r1.row   = r;
				r1.index = i;
				r1.last  = 1'b1;
				n        = 2;
			end
		end
		upper_store[i]  = middle_store[i];
		middle_store[i] = smp;
		byte_pos = i + 1;
		if (byte_pos >= bytes) begin
			byte_pos = 0;
			row_pos  = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	task automatic send_sample(input logic [SMP_W-1:0] smp, input logic [1:0] n_typed,
			input sharp_result_t t0, input sharp_result_t t1);
		int            n;
		sharp_result_t p0;
		sharp_result_t p1;
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_sharpen(smp, n, p0, p1);
		if (n_typed != 0) begin
			n  = n_typed;
			p0 = t0;
			p1 = t1;
		end
		if (n > 0)
			sharp_expected.push_back(p0);
		if (n > 1)
			sharp_expected.push_back(p1);
	endtask

	// hold the sender off until every pending result is out
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sharp_expected.size() != 0);
	endtask

	// drain, then give first-row items still in flight time to land
	task automatic settle_block();
		wait_for_results();
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_FRAME_WIDTH: begin
				width_reg = data[FW_W-1:0];
			end
			REG_FRAME_HEIGHT: begin
				height_reg = data[FH_W-1:0];
			end
			REG_CHANNEL_COUNT: begin
				chan_reg = data[CC_W-1:0];
			end
			default: begin
			end
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random(input int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(39) == 0)
				wait_for_results();
			send_sample(SMP_W'($urandom_range(255)), 2'd0, '0, '0);
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_result = '{m_axis_tdata[7:0], m_axis_tdata[19:8], m_axis_tdata[32:20],
				m_axis_tlast};
			if (sharp_expected.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected item: value %0d row %0d index %0d last %0d",
						got_result.value, got_result.row, got_result.index,
						got_result.last);
			end else begin
				want_result = sharp_expected.pop_front();
				if (got_result !== want_result || m_axis_tdata[OUT_DATA_W-1:33] !== '0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display({"mismatch: expected value %0d row %0d index %0d last %0d,",
							" got value %0d row %0d index %0d last %0d pad %h"},
							want_result.value, want_result.row, want_result.index,
							want_result.last, got_result.value, got_result.row,
							got_result.index, got_result.last,
							m_axis_tdata[OUT_DATA_W-1:33]);
				end
			end
		end
	end

	initial begin
		int               sent;
		int               count;
		int unsigned      frame_len;
		logic [FW_W-1:0]  w_raw;
		logic [FH_W-1:0]  h_raw;
		logic [CC_W-1:0]  c_raw;
		bit               calm;

		width_reg  = FW_RESET;
		height_reg = FH_RESET;
		chan_reg   = CC_RESET;
		row_pos    = 0;
		byte_pos   = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// raw zero clamps to the minimum width and one channel
		write_reg(REG_FRAME_WIDTH, '0);
		write_reg(REG_CHANNEL_COUNT, '0);
		foreach (DIR_TABLE[k]) begin
			if (DIR_TABLE[k].height != 0) begin
				settle_block();
				write_reg(REG_FRAME_HEIGHT, DIR_TABLE[k].height);
			end
			send_sample(DIR_TABLE[k].sample, DIR_TABLE[k].n_typed, DIR_TABLE[k].first,
				DIR_TABLE[k].second);
		end

		// Shrink the height while the row counter sits past it, then run one
		// full frame of the widest row the random part uses: this writes every
		// line store entry that a later item can read.
		settle_block();
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(FILL_WIDTH));
		write_reg(REG_CHANNEL_COUNT, 13'd7);
		send_random(3 * FILL_WIDTH * MAX_CH);

		// stop early in a row, shrink the row so the index restarts, then run
		// a few rows under the clamped tallest height
		send_random(10);
		settle_block();
		write_reg(REG_FRAME_WIDTH, 13'd2);
		write_reg(REG_CHANNEL_COUNT, 13'd1);
		write_reg(REG_FRAME_HEIGHT, 13'd8191);
		send_random(3 * TALL_ROWS);

		for (int ph = 0; ph < 4; ph++) begin
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				settle_block();
				case ($urandom_range(9))
					8: w_raw = FW_W'($urandom_range(0, 2));
					9: w_raw = FW_W'($urandom_range(9, FILL_WIDTH));
					default: w_raw = FW_W'($urandom_range(3, 8));
				endcase
				h_raw = ($urandom_range(3) == 0) ? FH_W'($urandom_range(0, 2))
					: FH_W'($urandom_range(3, 6));
				c_raw = CC_W'($urandom_range(7));
				write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w_raw));
				write_reg(REG_FRAME_HEIGHT, h_raw);
				write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(c_raw));
				if ($urandom_range(7) == 0)
					write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(8191)));
				frame_len = cur_bytes() * cur_height();
				// mostly whole frames, sometimes a run cut off mid-frame
				if ($urandom_range(3) != 0)
					count = frame_len * $urandom_range(1, 2);
				else
					count = $urandom_range(1, frame_len);
				calm      = ($urandom_range(3) == 0);
				idle_pct  = calm ? 0 : SEND_IDLE[ph];
				stall_pct = calm ? 0 : RECV_STALL[ph];
				send_random(count);
				sent += count;
			end
		end

		settle_block();
		if (fail_count == 0 && sharp_expected.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
